[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/rbc_pkg.sv]
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rbc_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int ADDR_W    = 12;
    localparam int CNT_W     = 13;
    localparam int DIM_W     = 7;
    localparam int TALLY_W   = 12;
    localparam logic [TALLY_W-1:0] TALLY_MAX = 12'hFFF;

    // register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic load;
        logic frame_begin;
        logic clr;
        logic blob_init;
        logic scan_adv;
        logic q_rd;
        logic pop_upd;
        logic nb_rd;
        logic nb_push;
        logic k_inc;
        logic blob_end;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic total_zero;
        logic clr_last;
        logic scan_end;
        logic hit;
        logic q_empty;
        logic nb_oob;
        logic k_last;
    } t_sts;

endpackage

[rtl/core/rectangular_blob_counter.sv]
// ----------------------------------------------------------------------------
// rectangular_blob_counter
// Counts 4-connected blobs of a binary image that fill their bounding box.
// ----------------------------------------------------------------------------
// Channel   | Ports                                   | Handshake
// pixel in  | i_pixel_set, i_last_pixel               | i_start & !o_busy
// config    | i_cfg_index, i_cfg_data                 | i_cfg_we
// result    | o_rect_count                            | o_rect_valid, one cycle
//
// A pixel without last_pixel is taken while busy stays low.
// The last pixel starts a clear pass over the rows*cols entries of the visited map
// (skipped for an empty image), then a raster scan of every pixel, plus for each
// blob pixel a queue read and up to four neighbor reads on the single-read
// image/visited ports, and a blob-end step per blob, then the result.
// Reset clears control state; the image, visited and queue memories are not reset.
// The receiver cannot stall: the count is shown for one cycle as busy ends.
module rectangular_blob_counter import rbc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_pixel_set,
    input  logic               i_last_pixel,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [DIM_W-1:0]   i_cfg_data,
    output logic               o_rect_valid,
    output logic [TALLY_W-1:0] o_rect_count
);

    t_cmd cmd;
    t_sts sts;

    rbc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_last_pixel (i_last_pixel),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_busy       (o_busy),
        .o_emit       (o_rect_valid)
    );

    rbc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel_set (i_pixel_set),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_tally     (o_rect_count)
    );

endmodule

[rtl/core/rbc_ctrl.sv]
// ----------------------------------------------------------------------------
// rbc_ctrl
// Sequencer for load, visited clear, raster scan and flood fill.
// ----------------------------------------------------------------------------
module rbc_ctrl import rbc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_last_pixel,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_emit
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLEAR    = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_SCAN_CHK = 4'd3;
    localparam logic [3:0] S_POP      = 4'd4;
    localparam logic [3:0] S_POP_WAIT = 4'd5;
    localparam logic [3:0] S_NB       = 4'd6;
    localparam logic [3:0] S_NB_CHK   = 4'd7;
    localparam logic [3:0] S_BLOB_END = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0] r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last_pixel) begin
                        o_cmd.frame_begin = 1'b1;
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                if (i_sts.total_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.clr = 1'b1;
                    if (i_sts.clr_last) n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_state = i_sts.scan_end ? S_DONE : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.hit) begin
                    o_cmd.blob_init = 1'b1;
                    n_state = S_POP;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_POP: begin
                if (i_sts.q_empty) begin
                    n_state = S_BLOB_END;
                end else begin
                    o_cmd.q_rd = 1'b1;
                    n_state = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                o_cmd.pop_upd = 1'b1;
                n_state = S_NB;
            end
            S_NB: begin
                if (i_sts.nb_oob) begin
                    if (i_sts.k_last) begin
                        n_state = S_POP;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                    end
                end else begin
                    o_cmd.nb_rd = 1'b1;
                    n_state = S_NB_CHK;
                end
            end
            S_NB_CHK: begin
                o_cmd.nb_push = i_sts.hit;
                if (i_sts.k_last) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_NB;
                end
            end
            S_BLOB_END: begin
                o_cmd.blob_end = 1'b1;
                o_cmd.scan_adv = 1'b1;
                n_state = S_SCAN;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_emit = (r_state == S_DONE);

endmodule

[rtl/core/rbc_dp.sv]
// ----------------------------------------------------------------------------
// rbc_dp
// Image, visited and queue memories, scan and fill counters, box tracking.
// ----------------------------------------------------------------------------
module rbc_dp import rbc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [DIM_W-1:0]   i_cfg_data,
    input  logic               i_pixel_set,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic [TALLY_W-1:0] o_tally
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam logic [DIM_W-1:0] MAXR = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] MAXC = DIM_W'(MAX_COLS);

    logic                     image_mem [DEPTH];
    logic                     vis_mem   [DEPTH];
    logic [ROW_W+COL_W-1:0]   queue_mem [DEPTH];

    logic [DIM_W-1:0] r_cfg_rows, r_cfg_cols;
    logic [DIM_W-1:0] rows_c, cols_c;
    logic [CNT_W-1:0] total_now;
    logic [CNT_W-1:0] r_load_addr;

    logic [DIM_W-1:0] r_rows, r_cols;
    logic [CNT_W-1:0] r_total, r_clr, r_sa;
    logic [ROW_W-1:0] r_sr;
    logic [COL_W-1:0] r_sc;

    logic [CNT_W-1:0] r_head, r_tail;
    logic [ROW_W-1:0] r_cr, r_min_r, r_max_r, r_nr;
    logic [COL_W-1:0] r_cc, r_min_c, r_max_c, r_nc;
    logic [ADDR_W-1:0] r_na;
    logic [1:0]       r_k;
    logic [CNT_W-1:0] r_pix;
    logic [TALLY_W-1:0] r_tally;

    logic                   r_img_q, r_vis_q;
    logic [ROW_W+COL_W-1:0] r_q;

    logic [ROW_W-1:0] nr;
    logic [COL_W-1:0] nc;
    logic             oob;
    logic [ADDR_W-1:0] na, rd_addr;
    logic [ROW_W:0]   rsum;
    logic [COL_W:0]   csum;
    logic [2*DIM_W-1:0] area;
    logic [ROW_W-1:0] qr;
    logic [COL_W-1:0] qc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= MAXR;
            r_cfg_cols <= MAXC;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ROWS) r_cfg_rows <= i_cfg_data;
            else                         r_cfg_cols <= i_cfg_data;
        end
    end

    assign rows_c    = (r_cfg_rows > MAXR) ? MAXR : r_cfg_rows;
    assign cols_c    = (r_cfg_cols > MAXC) ? MAXC : r_cfg_cols;
    assign total_now = {{(CNT_W-DIM_W){1'b0}}, rows_c} * {{(CNT_W-DIM_W){1'b0}}, cols_c};

    // neighbor of the current pixel, k = up, down, left, right
    always_comb begin
        nr   = r_cr;
        nc   = r_cc;
        oob  = 1'b0;
        rsum = {1'b0, r_cr} + 1'b1;
        csum = {1'b0, r_cc} + 1'b1;
        case (r_k)
            2'd0: begin
                nr  = r_cr - 1'b1;
                oob = (r_cr == '0);
            end
            2'd1: begin
                nr  = rsum[ROW_W-1:0];
                oob = ({1'b0, rsum} >= {1'b0, r_rows});
            end
            2'd2: begin
                nc  = r_cc - 1'b1;
                oob = (r_cc == '0);
            end
            default: begin
                nc  = csum[COL_W-1:0];
                oob = ({1'b0, csum} >= {1'b0, r_cols});
            end
        endcase
    end

    assign na      = ADDR_W'(nr * r_cols + {{(ROW_W+1){1'b0}}, nc});
    assign rd_addr = i_cmd.nb_rd ? na : r_sa[ADDR_W-1:0];
    assign qr      = r_q[ROW_W+COL_W-1:COL_W];
    assign qc      = r_q[COL_W-1:0];
    assign area    = ({1'b0, r_max_r - r_min_r} + 1'b1) * ({1'b0, r_max_c - r_min_c} + 1'b1);

    // image memory: load writes, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_load_addr < total_now))
            image_mem[r_load_addr[ADDR_W-1:0]] <= i_pixel_set;
        r_img_q <= image_mem[rd_addr];
    end

    // visited memory: clear, mark on blob start, mark on push
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr)
            vis_mem[r_clr[ADDR_W-1:0]] <= 1'b0;
        else if (i_cmd.blob_init)
            vis_mem[r_sa[ADDR_W-1:0]] <= 1'b1;
        else if (i_cmd.nb_push)
            vis_mem[r_na] <= 1'b1;
        r_vis_q <= vis_mem[rd_addr];
    end

    // fill queue memory: seed goes to slot 0, pushes go to the tail
    always_ff @(posedge i_clk) begin
        if (i_cmd.blob_init)
            queue_mem[{ADDR_W{1'b0}}] <= {r_sr, r_sc};
        else if (i_cmd.nb_push)
            queue_mem[r_tail[ADDR_W-1:0]] <= {r_nr, r_nc};
        if (i_cmd.q_rd)
            r_q <= queue_mem[r_head[ADDR_W-1:0]];
    end

    // load address, frame latch, clear and scan counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_addr <= '0;
            r_tally     <= '0;
            r_rows      <= MAXR;
            r_cols      <= MAXC;
            r_total     <= '0;
            r_clr       <= '0;
            r_sa        <= '0;
            r_sr        <= '0;
            r_sc        <= '0;
        end else begin
            if (i_cmd.frame_begin) begin
                r_load_addr <= '0;
                r_rows      <= rows_c;
                r_cols      <= cols_c;
                r_total     <= total_now;
                r_clr       <= '0;
                r_sa        <= '0;
                r_sr        <= '0;
                r_sc        <= '0;
                r_tally     <= '0;
            end else if (i_cmd.load && (r_load_addr < total_now)) begin
                r_load_addr <= r_load_addr + 1'b1;
            end
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.scan_adv) begin
                r_sa <= r_sa + 1'b1;
                if ({1'b0, r_sc} == r_cols - 1'b1) begin
                    r_sc <= '0;
                    r_sr <= r_sr + 1'b1;
                end else begin
                    r_sc <= r_sc + 1'b1;
                end
            end
            // solid rectangle test, tally saturates
            if (i_cmd.blob_end && ({1'b0, r_pix} == area) && (r_tally != TALLY_MAX))
                r_tally <= r_tally + 1'b1;
        end
    end

    // flood fill queue pointers, box and pixel count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_k    <= '0;
        end else begin
            if (i_cmd.blob_init) begin
                r_head <= '0;
                r_tail <= CNT_W'(1);
            end else if (i_cmd.nb_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (i_cmd.q_rd) r_head <= r_head + 1'b1;
            if (i_cmd.pop_upd)    r_k <= '0;
            else if (i_cmd.k_inc) r_k <= r_k + 1'b1;
        end
    end

    // payload for box and neighbor tracking
    always_ff @(posedge i_clk) begin
        if (i_cmd.blob_init) begin
            r_min_r <= r_sr;
            r_max_r <= r_sr;
            r_min_c <= r_sc;
            r_max_c <= r_sc;
            r_pix   <= '0;
        end
        if (i_cmd.pop_upd) begin
            r_cr  <= qr;
            r_cc  <= qc;
            r_pix <= r_pix + 1'b1;
            if (qr < r_min_r) r_min_r <= qr;
            if (qr > r_max_r) r_max_r <= qr;
            if (qc < r_min_c) r_min_c <= qc;
            if (qc > r_max_c) r_max_c <= qc;
        end
        if (i_cmd.nb_rd) begin
            r_nr <= nr;
            r_nc <= nc;
            r_na <= na;
        end
    end

    // status
    assign o_sts.total_zero = (r_total == '0);
    assign o_sts.clr_last   = (r_clr == r_total - 1'b1);
    assign o_sts.scan_end   = (r_sa == r_total);
    assign o_sts.hit        = r_img_q & ~r_vis_q;
    assign o_sts.q_empty    = (r_head == r_tail);
    assign o_sts.nb_oob     = oob;
    assign o_sts.k_last     = (r_k == 2'd3);
    assign o_tally          = r_tally;

endmodule

[rtl/core/rbc_checker.sv]
// ----------------------------------------------------------------------------
// rbc_checker
// Port-level checks of the blob counter's frame sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbc_checker import rbc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               i_last_pixel,
    input logic               o_rect_valid,
    input logic [TALLY_W-1:0] o_rect_count
);

    // a plain pixel never makes the block busy
    `ASSERT_NXT(a_pix_free, i_clk, i_rst_n, i_start && !o_busy && !i_last_pixel, !o_busy)
    // the frame's last pixel starts labeling
    `ASSERT_NXT(a_last_busy, i_clk, i_rst_n, i_start && !o_busy && i_last_pixel, o_busy)
    // result strobe lasts one cycle and ends the busy period
    `ASSERT_NXT(a_one_shot, i_clk, i_rst_n, o_rect_valid, !o_rect_valid && !o_busy)
    // a result comes only out of a busy period
    `ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_rect_valid, o_busy)
    // at most half the pixels can start solid blobs
    `ASSERT_IMP(a_count_range, i_clk, i_rst_n, o_rect_valid, o_rect_count <= 12'd2048)

endmodule

bind rectangular_blob_counter rbc_checker u_rbc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .i_last_pixel (i_last_pixel),
    .o_rect_valid (o_rect_valid),
    .o_rect_count (o_rect_count)
);
